FILE: rtl/opp_pkg.sv
// Package for the operator-precedence expression parser.
// Holds the transaction types, symbol and class codes, the precedence table and the FSM states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package opp_pkg;

  localparam int unsigned STACK_DEPTH_DEFAULT = 32;
  localparam int unsigned SYM_W = 7;
  localparam int unsigned RUN_CNT_W = 6;
  localparam logic [RUN_CNT_W-1:0] RUN_LIMIT = 6'd33;

  localparam logic [SYM_W-1:0] SYM_NT     = 7'd64;
  localparam logic [SYM_W-1:0] SYM_HANDLE = 7'd65;
  localparam logic [SYM_W-1:0] SYM_BOTTOM = 7'd66;

  localparam logic [3:0] CLS_ADD    = 4'd0;
  localparam logic [3:0] CLS_MUL    = 4'd1;
  localparam logic [3:0] CLS_REL    = 4'd2;
  localparam logic [3:0] CLS_NOTNIL = 4'd3;
  localparam logic [3:0] CLS_COAL   = 4'd4;
  localparam logic [3:0] CLS_LPAR   = 4'd5;
  localparam logic [3:0] CLS_RPAR   = 4'd6;
  localparam logic [3:0] CLS_OPND   = 4'd7;
  localparam logic [3:0] CLS_END    = 4'd8;
  localparam logic [3:0] ROW_DOLLAR = 4'd8;

  localparam logic [2:0] VAR_ADD_MAX = 3'd1;
  localparam logic [2:0] VAR_REL_MAX = 3'd5;

  typedef enum logic [2:0] {
    ACT_ERR,
    ACT_SHIFT,
    ACT_REDUCE,
    ACT_EQUAL,
    ACT_END
  } opp_act_e;

  typedef enum logic [1:0] {
    EV_REDUCED,
    EV_ACCEPT,
    EV_ERROR,
    EV_OVERFLOW
  } opp_kind_e;

  typedef enum logic [2:0] {
    RULE_PAREN,
    RULE_OPERAND,
    RULE_ADD,
    RULE_MUL,
    RULE_REL,
    RULE_COAL,
    RULE_NOTNIL
  } opp_rule_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SH_MARK,
    ST_SH_MID,
    ST_SH_TOK,
    ST_EQ_PUSH,
    ST_RED,
    ST_RD2,
    ST_REDX,
    ST_WB,
    ST_REFILL,
    ST_FLUSH
  } opp_state_e;

  typedef struct packed {
    logic [3:0] token_class;
    logic [2:0] op_variant;
  } opp_in_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [2:0] rule_used;
    logic [2:0] reduced_variant;
    logic       last_of_run;
  } opp_out_t;

  typedef struct packed {
    logic [1:0]       cnt;
    logic [SYM_W-1:0] a;
    logic [SYM_W-1:0] b;
    logic [SYM_W-1:0] c;
  } opp_match_req_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] rule;
    logic [2:0] variant;
  } opp_match_t;

  localparam opp_act_e PREC_TABLE [9][9] = '{
    '{ACT_REDUCE, ACT_SHIFT, ACT_REDUCE, ACT_SHIFT, ACT_REDUCE, ACT_SHIFT, ACT_REDUCE,
      ACT_SHIFT, ACT_REDUCE},
    '{ACT_REDUCE, ACT_REDUCE, ACT_REDUCE, ACT_SHIFT, ACT_REDUCE, ACT_SHIFT, ACT_REDUCE,
      ACT_SHIFT, ACT_REDUCE},
    '{ACT_SHIFT, ACT_SHIFT, ACT_ERR, ACT_SHIFT, ACT_REDUCE, ACT_SHIFT, ACT_REDUCE,
      ACT_SHIFT, ACT_REDUCE},
    '{ACT_REDUCE, ACT_REDUCE, ACT_REDUCE, ACT_ERR, ACT_REDUCE, ACT_ERR, ACT_REDUCE,
      ACT_ERR, ACT_REDUCE},
    '{ACT_SHIFT, ACT_SHIFT, ACT_SHIFT, ACT_SHIFT, ACT_SHIFT, ACT_SHIFT, ACT_REDUCE,
      ACT_SHIFT, ACT_REDUCE},
    '{ACT_SHIFT, ACT_SHIFT, ACT_SHIFT, ACT_SHIFT, ACT_SHIFT, ACT_SHIFT, ACT_EQUAL,
      ACT_SHIFT, ACT_ERR},
    '{ACT_REDUCE, ACT_REDUCE, ACT_REDUCE, ACT_REDUCE, ACT_REDUCE, ACT_ERR, ACT_SHIFT,
      ACT_ERR, ACT_REDUCE},
    '{ACT_REDUCE, ACT_REDUCE, ACT_REDUCE, ACT_REDUCE, ACT_REDUCE, ACT_ERR, ACT_REDUCE,
      ACT_ERR, ACT_REDUCE},
    '{ACT_SHIFT, ACT_SHIFT, ACT_SHIFT, ACT_SHIFT, ACT_SHIFT, ACT_SHIFT, ACT_ERR,
      ACT_SHIFT, ACT_END}
  };

endpackage

`default_nettype wire

FILE: rtl/opp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the symbol stack. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module opp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/opp_rule_match.sv
// Handle matcher: checks the symbols above a handle marker against the grammar rules.
// Depends on opp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module opp_rule_match
  import opp_pkg::*;
(
  input  wire opp_match_req_t req_i,
  output opp_match_t          res_o
);

  logic [3:0] a_cls;
  logic [3:0] b_cls;
  logic [3:0] c_cls;
  logic       a_term;
  logic       b_term;
  logic       c_term;

  assign a_cls  = {1'b0, req_i.a[5:3]};
  assign b_cls  = {1'b0, req_i.b[5:3]};
  assign c_cls  = {1'b0, req_i.c[5:3]};
  assign a_term = !req_i.a[6];
  assign b_term = !req_i.b[6];
  assign c_term = !req_i.c[6];

  always_comb begin
    res_o = '0;
    case (req_i.cnt)
      2'd1: begin
        if (a_term && a_cls == CLS_OPND) begin
          res_o.ok   = 1'b1;
          res_o.rule = RULE_OPERAND;
        end
      end
      2'd2: begin
        if (req_i.a == SYM_NT && b_term && b_cls == CLS_NOTNIL) begin
          res_o.ok   = 1'b1;
          res_o.rule = RULE_NOTNIL;
        end
      end
      2'd3: begin
        if (a_term && a_cls == CLS_LPAR && req_i.b == SYM_NT && c_term && c_cls == CLS_RPAR)
        begin
          res_o.ok   = 1'b1;
          res_o.rule = RULE_PAREN;
        end else if (req_i.a == SYM_NT && req_i.c == SYM_NT && b_term) begin
          if (b_cls inside {CLS_ADD, CLS_MUL} && req_i.b[2:0] <= VAR_ADD_MAX) begin
            res_o.ok      = 1'b1;
            res_o.rule    = (b_cls == CLS_ADD) ? RULE_ADD : RULE_MUL;
            res_o.variant = req_i.b[2:0];
          end else if (b_cls == CLS_REL && req_i.b[2:0] <= VAR_REL_MAX) begin
            res_o.ok      = 1'b1;
            res_o.rule    = RULE_REL;
            res_o.variant = req_i.b[2:0];
          end else if (b_cls == CLS_COAL) begin
            res_o.ok   = 1'b1;
            res_o.rule = RULE_COAL;
          end
        end
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/operator_precedence_expr_parser_top.sv
// Top level of the operator-precedence expression parser: sequencer, stack caches, output queue.
// Depends on opp_pkg, opp_ram and opp_rule_match.
//
// Usage: one token transaction enters on in_valid_i/in_data_i when in_stall_o is low; the
// block raises in_stall_o while it works on that token and lowers it once all of the
// token's results have been handed on. Results leave on out_valid_o/out_data_o and are
// taken when out_stall_i is low; last_of_run marks the final result of a token.
// Steps, as set by the sequencer and the single read port of the symbol stack RAM:
// a shift passes decide, two or three stack writes and flush; a reduction passes
// decide, match, write-back and refill when the handle lies one below the top, and
// decide, two reads, match, write-back and refill otherwise; an accept, error or
// overflow found in decide goes on to flush.
// One result waits internally and one in the output register, so the parser runs on
// while the receiver stalls until a third result is due; it then waits for the output.
// Reset empties the stack at once (only the top two entries are cached in flip-flops
// and the bottom marker is supplied by logic), so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module operator_precedence_expr_parser_top
  import opp_pkg::*;
#(
  parameter int unsigned StackDepth = STACK_DEPTH_DEFAULT
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire opp_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output opp_out_t      out_data_o
);

  localparam int unsigned PtrW = $clog2(StackDepth);
  localparam logic [PtrW:0] LastIdx = (PtrW + 1)'(StackDepth - 1);

  opp_state_e state_q, state_d;
  logic [PtrW-1:0]      top_q, top_d;
  logic [SYM_W-1:0]     t0_q, t0_d;
  logic [SYM_W-1:0]     t1_q, t1_d;
  logic [SYM_W-1:0]     s2_q, s2_d;
  logic [3:0]           cls_q, cls_d;
  logic [2:0]           var_q, var_d;
  logic                 eq_q, eq_d;
  logic [RUN_CNT_W-1:0] n_q, n_d;
  logic                 pend_valid_q, pend_valid_d;
  opp_out_t             pend_q, pend_d;
  logic                 out_valid_q, out_valid_d;
  opp_out_t             out_q, out_d;

  logic                 ram_we;
  logic [PtrW-1:0]      ram_waddr;
  logic [SYM_W-1:0]     ram_wdata;
  logic [PtrW-1:0]      ram_raddr;
  logic [SYM_W-1:0]     ram_rdata;

  opp_match_req_t       match_req;
  opp_match_t           match_res;

  logic                 out_free;
  logic                 hold;
  logic                 emit_req;
  opp_out_t             emit_item;
  logic                 clear_req;
  logic                 flush_fire;
  logic                 out_load;

  logic [SYM_W-1:0]     term_sym;
  logic [3:0]           row;
  opp_act_e             act;
  logic [SYM_W-1:0]     tok_sym;
  logic [SYM_W-1:0]     mid_sym;
  logic                 is_end;
  logic                 accept_cond;
  logic                 shift_ovf;
  logic                 eq_ovf;
  logic                 red_fail;
  logic                 red_more;
  logic                 redx_hit;
  logic [PtrW-1:0]      redx_cnt;

  opp_ram #(
    .Width(SYM_W),
    .Depth(StackDepth)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  opp_rule_match u_match (
    .req_i(match_req),
    .res_o(match_res)
  );

  assign term_sym    = (t0_q == SYM_NT) ? t1_q : t0_q;
  assign row         = term_sym[6] ? ROW_DOLLAR : {1'b0, term_sym[5:3]};
  assign act         = PREC_TABLE[row][cls_q];
  assign tok_sym     = {1'b0, cls_q[2:0], (cls_q <= CLS_REL) ? var_q : 3'd0};
  assign mid_sym     = (t0_q == SYM_NT) ? SYM_NT : SYM_HANDLE;
  assign is_end      = (cls_q == CLS_END);
  assign accept_cond = (top_q == PtrW'(1)) && (t0_q == SYM_NT);
  assign shift_ovf   = ({1'b0, top_q} + (PtrW + 1)'(2)) > LastIdx;
  assign eq_ovf      = ({1'b0, top_q} + (PtrW + 1)'(1)) > LastIdx;
  assign red_fail    = (top_q == '0) || (t0_q == SYM_HANDLE) || (top_q == PtrW'(1)) ||
                       ((t1_q != SYM_HANDLE) && (top_q == PtrW'(2)));
  assign red_more    = (t1_q != SYM_HANDLE);
  assign redx_hit    = (s2_q == SYM_HANDLE) ||
                       ((top_q != PtrW'(3)) && (ram_rdata == SYM_HANDLE));
  assign redx_cnt    = (s2_q == SYM_HANDLE) ? PtrW'(2) : PtrW'(3);

  assign out_free    = !out_valid_q || !out_stall_i;
  assign hold        = pend_valid_q && !out_free;

  always_comb begin
    match_req = '0;
    if (state_q == ST_REDX) begin
      if (s2_q == SYM_HANDLE) begin
        match_req.cnt = 2'd2;
        match_req.a   = t1_q;
        match_req.b   = t0_q;
      end else begin
        match_req.cnt = 2'd3;
        match_req.a   = s2_q;
        match_req.b   = t1_q;
        match_req.c   = t0_q;
      end
    end else begin
      match_req.cnt = 2'd1;
      match_req.a   = t0_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_data_i.token_class > CLS_END) ? ST_FLUSH : ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!hold) begin
          if (is_end) begin
            state_d = (!accept_cond && act == ACT_REDUCE) ? ST_RED : ST_FLUSH;
          end else begin
            case (act)
              ACT_SHIFT: begin
                if (shift_ovf) begin
                  state_d = ST_FLUSH;
                end else begin
                  state_d = (t0_q == SYM_NT) ? ST_SH_MARK : ST_SH_MID;
                end
              end
              ACT_REDUCE: state_d = ST_RED;
              ACT_EQUAL:  state_d = eq_ovf ? ST_FLUSH : ST_EQ_PUSH;
              default:    state_d = ST_FLUSH;
            endcase
          end
        end
      end
      ST_SH_MARK: state_d = ST_SH_MID;
      ST_SH_MID:  state_d = ST_SH_TOK;
      ST_SH_TOK:  state_d = ST_FLUSH;
      ST_EQ_PUSH: state_d = ST_RED;
      ST_RED: begin
        if (!hold) begin
          if (n_q >= RUN_LIMIT || red_fail) begin
            state_d = ST_FLUSH;
          end else if (!red_more) begin
            state_d = match_res.ok ? ST_WB : ST_FLUSH;
          end else begin
            state_d = ST_RD2;
          end
        end
      end
      ST_RD2: state_d = ST_REDX;
      ST_REDX: begin
        if (!hold) begin
          state_d = (redx_hit && match_res.ok) ? ST_WB : ST_FLUSH;
        end
      end
      ST_WB:     state_d = ST_REFILL;
      ST_REFILL: state_d = eq_q ? ST_FLUSH : ST_DECIDE;
      ST_FLUSH: begin
        if (!pend_valid_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    top_d     = top_q;
    t0_d      = t0_q;
    t1_d      = t1_q;
    s2_d      = s2_q;
    cls_d     = cls_q;
    var_d     = var_q;
    eq_d      = eq_q;
    ram_we    = 1'b0;
    ram_waddr = top_q;
    ram_wdata = SYM_NT;
    ram_raddr = top_q;
    emit_req  = 1'b0;
    emit_item = '0;
    clear_req = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cls_d = in_data_i.token_class;
          var_d = in_data_i.op_variant;
          eq_d  = 1'b0;
          if (in_data_i.token_class > CLS_END) begin
            emit_req             = 1'b1;
            emit_item.event_kind = EV_ERROR;
            clear_req            = 1'b1;
          end
        end
      end
      ST_DECIDE: begin
        if (!hold) begin
          if (is_end) begin
            if (accept_cond) begin
              emit_req             = 1'b1;
              emit_item.event_kind = EV_ACCEPT;
              clear_req            = 1'b1;
            end else if (act != ACT_REDUCE) begin
              emit_req             = 1'b1;
              emit_item.event_kind = EV_ERROR;
              clear_req            = 1'b1;
            end
          end else begin
            case (act)
              ACT_SHIFT: begin
                if (shift_ovf) begin
                  emit_req             = 1'b1;
                  emit_item.event_kind = EV_OVERFLOW;
                  clear_req            = 1'b1;
                end
              end
              ACT_REDUCE: begin
                emit_req = 1'b0;
              end
              ACT_EQUAL: begin
                if (eq_ovf) begin
                  emit_req             = 1'b1;
                  emit_item.event_kind = EV_OVERFLOW;
                  clear_req            = 1'b1;
                end
              end
              default: begin
                emit_req             = 1'b1;
                emit_item.event_kind = EV_ERROR;
                clear_req            = 1'b1;
              end
            endcase
          end
        end
      end
      ST_SH_MARK: begin
        ram_we    = 1'b1;
        ram_waddr = top_q;
        ram_wdata = SYM_HANDLE;
      end
      ST_SH_MID: begin
        ram_we    = 1'b1;
        ram_waddr = top_q + PtrW'(1);
        ram_wdata = mid_sym;
      end
      ST_SH_TOK: begin
        ram_we    = 1'b1;
        ram_waddr = top_q + PtrW'(2);
        ram_wdata = tok_sym;
        top_d     = top_q + PtrW'(2);
        t1_d      = mid_sym;
        t0_d      = tok_sym;
      end
      ST_EQ_PUSH: begin
        ram_we    = 1'b1;
        ram_waddr = top_q + PtrW'(1);
        ram_wdata = tok_sym;
        top_d     = top_q + PtrW'(1);
        t1_d      = t0_q;
        t0_d      = tok_sym;
        eq_d      = 1'b1;
      end
      ST_RED: begin
        ram_raddr = top_q - PtrW'(2);
        if (!hold) begin
          if (n_q >= RUN_LIMIT) begin
            emit_req             = 1'b1;
            emit_item.event_kind = EV_OVERFLOW;
            clear_req            = 1'b1;
          end else if (red_fail || (!red_more && !match_res.ok)) begin
            emit_req             = 1'b1;
            emit_item.event_kind = EV_ERROR;
            clear_req            = 1'b1;
          end else if (!red_more) begin
            emit_req                  = 1'b1;
            emit_item.event_kind      = EV_REDUCED;
            emit_item.rule_used       = match_res.rule;
            emit_item.reduced_variant = match_res.variant;
            top_d                     = top_q - PtrW'(1);
          end
        end
      end
      ST_RD2: begin
        s2_d      = ram_rdata;
        ram_raddr = top_q - PtrW'(3);
      end
      ST_REDX: begin
        ram_raddr = top_q - PtrW'(3);
        if (!hold) begin
          emit_req = 1'b1;
          if (redx_hit && match_res.ok) begin
            emit_item.event_kind      = EV_REDUCED;
            emit_item.rule_used       = match_res.rule;
            emit_item.reduced_variant = match_res.variant;
            top_d                     = top_q - redx_cnt;
          end else begin
            emit_item.event_kind = EV_ERROR;
            clear_req            = 1'b1;
          end
        end
      end
      ST_WB: begin
        ram_we    = 1'b1;
        ram_waddr = top_q;
        ram_wdata = SYM_NT;
        ram_raddr = top_q - PtrW'(1);
        t0_d      = SYM_NT;
      end
      ST_REFILL: begin
        t1_d = (top_q == PtrW'(1)) ? SYM_BOTTOM : ram_rdata;
      end
      ST_FLUSH: begin
        emit_req = 1'b0;
      end
      default: begin
        emit_req = 1'b0;
      end
    endcase
    if (clear_req) begin
      top_d = '0;
      t0_d  = SYM_BOTTOM;
      t1_d  = SYM_BOTTOM;
    end
    if (state_q == ST_IDLE) begin
      n_d = '0;
    end else if (emit_req) begin
      n_d = n_q + RUN_CNT_W'(1);
    end else begin
      n_d = n_q;
    end
  end

  // A new result displaces the waiting one into the output register; the flush marks the
  // waiting one as the last of its token.
  always_comb begin
    flush_fire   = (state_q == ST_FLUSH) && pend_valid_q && out_free;
    out_load     = (emit_req && pend_valid_q) || flush_fire;
    out_d        = out_q;
    if (out_load) begin
      out_d             = pend_q;
      out_d.last_of_run = flush_fire;
    end
    out_valid_d  = out_load || (out_valid_q && out_stall_i);
    pend_d       = emit_req ? emit_item : pend_q;
    pend_valid_d = emit_req || (pend_valid_q && !flush_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      top_q        <= '0;
      t0_q         <= SYM_BOTTOM;
      t1_q         <= SYM_BOTTOM;
      eq_q         <= 1'b0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      top_q        <= top_d;
      t0_q         <= t0_d;
      t1_q         <= t1_d;
      eq_q         <= eq_d;
      n_q          <= n_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_q   <= s2_d;
    cls_q  <= cls_d;
    var_q  <= var_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_top_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, top_q} <= LastIdx)
    else $error("stack pointer beyond the last entry");

  a_nt_above_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (t0_q == SYM_NT) |-> (top_q != '0))
    else $error("expression symbol cached at the bottom position");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_valid_q)
    else $error("result still pending while ready for a new token");

  a_bad_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.token_class > CLS_END) |=>
      (pend_valid_q && pend_q.event_kind == EV_ERROR && top_q == '0))
    else $error("unknown class did not raise a syntax error");

  a_flush_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_fire |=> (state_q == ST_IDLE && out_valid_q && out_q.last_of_run))
    else $error("final result of a token not marked as last");

endmodule

`default_nettype wire
